### rtl/htb_pkg.sv
// Shared types and codes for the handle table with bounds check.
`timescale 1ns / 1ps
`default_nettype none

package htb_pkg;

    localparam int ADDR_W   = 32;
    localparam int HANDLE_W = 32;
    localparam int OFFSET_W = 24;
    localparam int SIZE_W   = 24;
    localparam int TOP_W    = 8;
    localparam int STATUS_W = 3;
    localparam int CMD_W    = 2;

    localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_GETADDR = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ALLOC_FAIL = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_HANDLE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RANGE      = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic                top_ok;
        logic [TOP_W-1:0]    slot;
        logic [OFFSET_W-1:0] offset;
        logic [SIZE_W-1:0]   size;
        logic [ADDR_W-1:0]   heap_address;
    } item_t;

endpackage

`default_nettype wire

### rtl/htb_front.sv
// Front stage: accept a command word and decode its handle.
`timescale 1ns / 1ps
`default_nettype none

module htb_front #(
    parameter int SLOT_COUNT = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [htb_pkg::CMD_W-1:0]      command,
    input  wire logic [htb_pkg::HANDLE_W-1:0]   handle,
    input  wire logic [htb_pkg::SIZE_W-1:0]     size,
    input  wire logic [htb_pkg::ADDR_W-1:0]     heap_address,
    output logic                                q_valid,
    input  wire logic                           q_ready,
    output htb_pkg::item_t                      q_word
);

    logic                       fv_reg;
    logic                       fv_next;
    htb_pkg::item_t             word_reg;
    htb_pkg::item_t             word_next;
    logic [htb_pkg::TOP_W-1:0]  top;

    assign in_ready = !fv_reg || q_ready;
    assign q_valid  = fv_reg;
    assign q_word   = word_reg;
    assign top      = handle[htb_pkg::HANDLE_W-1:htb_pkg::OFFSET_W];

    always_comb
    begin
        word_next.cmd          = command;
        word_next.top_ok       = (top != '0) &&
                                 ({1'b0, top} <= (htb_pkg::TOP_W + 1)'(SLOT_COUNT));
        word_next.slot         = top - htb_pkg::TOP_W'(1);
        word_next.offset       = handle[htb_pkg::OFFSET_W-1:0];
        word_next.size         = size;
        word_next.heap_address = heap_address;
    end

    always_comb
    begin
        fv_next = fv_reg;
        if (in_valid && in_ready)
        begin
            fv_next = 1'b1;
        end
        else if (q_ready)
        begin
            fv_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= 1'b0;
        end
        else
        begin
            fv_reg <= fv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            word_reg <= word_next;
        end
    end

endmodule

`default_nettype wire

### rtl/htb_queue.sv
// Two-entry queue of decoded words between front and back.
`timescale 1ns / 1ps
`default_nettype none

module htb_queue (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push_valid,
    output logic           push_ready,
    input  htb_pkg::item_t push_word,
    output logic           pop_valid,
    input  wire logic      pop,
    output htb_pkg::item_t pop_word
);

    htb_pkg::item_t entry_reg [2];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;
    logic           do_push;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_word   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_word;
        end
    end

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != 2'd0)
        else $error("queue popped while empty");

endmodule

`default_nettype wire

### rtl/htb_back.sv
// Back end: slot table, occupancy, command execution and result register.
`timescale 1ns / 1ps
`default_nettype none

module htb_back #(
    parameter int SLOT_COUNT = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           q_valid,
    output logic                                q_pop,
    input  htb_pkg::item_t                      q_word,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [htb_pkg::STATUS_W-1:0]        status,
    output logic [htb_pkg::HANDLE_W-1:0]        new_handle,
    output logic [htb_pkg::ADDR_W-1:0]          resolved_address,
    output logic                                release_valid,
    output logic [htb_pkg::ADDR_W-1:0]          release_address,
    output logic                                last
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_RELRD = 2'd2;

    logic [1:0]                   state_reg;
    logic [1:0]                   state_next;
    logic [SLOT_COUNT-1:0]        occ_reg;
    logic [SLOT_COUNT-1:0]        occ_next;
    logic [SLOT_COUNT-1:0]        occ_left;
    htb_pkg::item_t               cur_reg;
    logic [IDX_W-1:0]             idx_reg;
    logic                         any_reg;
    logic [htb_pkg::ADDR_W-1:0]   rd_addr_reg;
    logic [htb_pkg::SIZE_W-1:0]   rd_size_reg;

    logic [htb_pkg::ADDR_W-1:0]   addr_mem [SLOT_COUNT];
    logic [htb_pkg::SIZE_W-1:0]   size_mem [SLOT_COUNT];

    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [htb_pkg::STATUS_W-1:0] status_reg;
    logic [htb_pkg::HANDLE_W-1:0] new_handle_reg;
    logic [htb_pkg::ADDR_W-1:0]   resolved_reg;
    logic                         rel_valid_reg;
    logic [htb_pkg::ADDR_W-1:0]   rel_addr_reg;
    logic                         last_reg;

    logic [IDX_W-1:0]             first_occ_idx;
    logic [IDX_W-1:0]             free_idx;
    logic                         free_found;
    logic [IDX_W-1:0]             head_idx;
    logic [IDX_W-1:0]             rd_idx;
    logic                         rd_en;
    logic                         exec_fire;
    logic                         hit;
    logic [htb_pkg::SIZE_W:0]     span;
    logic                         more;
    logic                         mem_we;
    logic                         occ_clr;

    logic [htb_pkg::STATUS_W-1:0] res_status;
    logic [htb_pkg::HANDLE_W-1:0] res_handle;
    logic [htb_pkg::ADDR_W-1:0]   res_resolved;
    logic                         res_rel_valid;
    logic [htb_pkg::ADDR_W-1:0]   res_rel_addr;
    logic                         res_last;

    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign new_handle       = new_handle_reg;
    assign resolved_address = resolved_reg;
    assign release_valid    = rel_valid_reg;
    assign release_address  = rel_addr_reg;
    assign last             = last_reg;

    always_comb
    begin
        first_occ_idx = '0;
        free_idx      = '0;
        free_found    = 1'b0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (occ_reg[i])
            begin
                first_occ_idx = IDX_W'(i);
            end
            else
            begin
                free_idx   = IDX_W'(i);
                free_found = 1'b1;
            end
        end
    end

    assign q_pop     = (state_reg == S_IDLE) && q_valid;
    assign head_idx  = q_word.top_ok ? q_word.slot[IDX_W-1:0] : '0;
    assign rd_idx    = ((state_reg == S_RELRD) || (q_word.cmd == htb_pkg::CMD_RELEASE)) ?
                       first_occ_idx : head_idx;
    assign rd_en     = q_pop || (state_reg == S_RELRD);
    assign exec_fire = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);
    assign hit       = cur_reg.top_ok && occ_reg[idx_reg];
    assign span      = {1'b0, cur_reg.offset} + {1'b0, cur_reg.size};

    always_comb
    begin
        occ_left          = occ_reg;
        occ_left[idx_reg] = 1'b0;
    end
    assign more = |occ_left;

    always_comb
    begin
        res_status    = htb_pkg::ST_OK;
        res_handle    = '0;
        res_resolved  = '0;
        res_rel_valid = 1'b0;
        res_rel_addr  = '0;
        res_last      = 1'b1;
        mem_we        = 1'b0;
        occ_clr       = 1'b0;
        case (cur_reg.cmd)
            htb_pkg::CMD_ALLOC:
            begin
                if (!free_found)
                begin
                    res_status    = htb_pkg::ST_FULL;
                    res_rel_valid = (cur_reg.heap_address != '0);
                    res_rel_addr  = cur_reg.heap_address;
                end
                else if (cur_reg.heap_address == '0)
                begin
                    res_status = htb_pkg::ST_ALLOC_FAIL;
                end
                else
                begin
                    mem_we     = 1'b1;
                    res_handle = {htb_pkg::TOP_W'(free_idx) + htb_pkg::TOP_W'(1),
                                  htb_pkg::OFFSET_W'(0)};
                end
            end
            htb_pkg::CMD_FREE:
            begin
                if (!hit || (cur_reg.offset != '0))
                begin
                    res_status = htb_pkg::ST_BAD_HANDLE;
                end
                else
                begin
                    occ_clr       = 1'b1;
                    res_rel_valid = 1'b1;
                    res_rel_addr  = rd_addr_reg;
                end
            end
            htb_pkg::CMD_GETADDR:
            begin
                if (!hit)
                begin
                    res_status = htb_pkg::ST_BAD_HANDLE;
                end
                else if ({1'b0, rd_size_reg} < span)
                begin
                    res_status = htb_pkg::ST_RANGE;
                end
                else
                begin
                    res_resolved = rd_addr_reg +
                                   {htb_pkg::TOP_W'(0), cur_reg.offset};
                end
            end
            htb_pkg::CMD_RELEASE:
            begin
                if (any_reg)
                begin
                    occ_clr       = 1'b1;
                    res_rel_valid = 1'b1;
                    res_rel_addr  = rd_addr_reg;
                    res_last      = !more;
                end
            end
            default:
            begin
                res_status = htb_pkg::ST_OK;
            end
        endcase
    end

    always_comb
    begin
        occ_next = occ_reg;
        if (exec_fire && mem_we)
        begin
            occ_next[free_idx] = 1'b1;
        end
        if (exec_fire && occ_clr)
        begin
            occ_next[idx_reg] = 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (exec_fire)
                begin
                    if ((cur_reg.cmd == htb_pkg::CMD_RELEASE) && any_reg && more)
                    begin
                        state_next = S_RELRD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_RELRD:
            begin
                state_next = S_EXEC;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (exec_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_word;
            any_reg <= |occ_reg;
        end
        if (rd_en)
        begin
            idx_reg <= rd_idx;
        end
        if (exec_fire)
        begin
            status_reg     <= res_status;
            new_handle_reg <= res_handle;
            resolved_reg   <= res_resolved;
            rel_valid_reg  <= res_rel_valid;
            rel_addr_reg   <= res_rel_addr;
            last_reg       <= res_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_fire && mem_we)
        begin
            addr_mem[free_idx] <= cur_reg.heap_address;
            size_mem[free_idx] <= cur_reg.size;
        end
        if (rd_en)
        begin
            rd_addr_reg <= addr_mem[rd_idx];
            rd_size_reg <= size_mem[rd_idx];
        end
    end

    a_release_all_empties: assert property (@(posedge clk) disable iff (!rst_n)
        exec_fire && (cur_reg.cmd == htb_pkg::CMD_RELEASE) && res_last
        |=> occ_reg == '0)
        else $error("table not empty after release all");

    a_alloc_takes_one_slot: assert property (@(posedge clk) disable iff (!rst_n)
        exec_fire && mem_we
        |=> $countones(occ_reg) == $countones($past(occ_reg)) + 1)
        else $error("alloc did not occupy exactly one slot");

    a_free_drops_one_slot: assert property (@(posedge clk) disable iff (!rst_n)
        exec_fire && occ_clr
        |=> $countones(occ_reg) + 1 == $countones($past(occ_reg)))
        else $error("free or release did not clear exactly one slot");

endmodule

`default_nettype wire

### rtl/handle_table_with_bounds_check.sv
// Top level of the handle table with bounds check.
//
//   channel   direction  handshake             words
//   in        input      in_valid / in_ready   command, handle, size, heap_address
//   out       output     out_valid / out_ready status, new_handle, resolved_address,
//                                              release_valid, release_address, last
//
// Every command: the input word passes the front register, the two-entry queue, the
// back end's current-word register and the result register before its first result
// is valid; the back end pops a word, then executes it, before it takes the next word.
// Release all: each occupied slot is read from the slot memory, then executed. Reset
// empties the table at once through the occupancy flops. Either side may stall: a
// queue decouples front and back, and a result register holds each result until taken.
`timescale 1ns / 1ps
`default_nettype none

module handle_table_with_bounds_check #(
    parameter int SLOT_COUNT = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [htb_pkg::CMD_W-1:0]      command,
    input  wire logic [htb_pkg::HANDLE_W-1:0]   handle,
    input  wire logic [htb_pkg::SIZE_W-1:0]     size,
    input  wire logic [htb_pkg::ADDR_W-1:0]     heap_address,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [htb_pkg::STATUS_W-1:0]        status,
    output logic [htb_pkg::HANDLE_W-1:0]        new_handle,
    output logic [htb_pkg::ADDR_W-1:0]          resolved_address,
    output logic                                release_valid,
    output logic [htb_pkg::ADDR_W-1:0]          release_address,
    output logic                                last
);

    logic           f_valid;
    logic           f_ready;
    htb_pkg::item_t f_word;
    logic           b_valid;
    logic           b_pop;
    htb_pkg::item_t b_word;

    htb_front #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .handle       (handle),
        .size         (size),
        .heap_address (heap_address),
        .q_valid      (f_valid),
        .q_ready      (f_ready),
        .q_word       (f_word)
    );

    htb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_word  (f_word),
        .pop_valid  (b_valid),
        .pop        (b_pop),
        .pop_word   (b_word)
    );

    htb_back #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_valid          (b_valid),
        .q_pop            (b_pop),
        .q_word           (b_word),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .status           (status),
        .new_handle       (new_handle),
        .resolved_address (resolved_address),
        .release_valid    (release_valid),
        .release_address  (release_address),
        .last             (last)
    );

endmodule

`default_nettype wire

### bench/testbench.sv
// Testbench for the handle table with bounds check: directed and random words, scoreboarded.
`timescale 1ns / 1ps

module testbench;

    localparam int SLOT_COUNT = 16;
    localparam int HALF_PERIOD = 6;
    localparam int SETTLE_CYCLES = 48;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [htb_pkg::STATUS_W-1:0] status;
        logic [htb_pkg::HANDLE_W-1:0] new_handle;
        logic [htb_pkg::ADDR_W-1:0]   resolved_address;
        logic                         release_valid;
        logic [htb_pkg::ADDR_W-1:0]   release_address;
        logic                         last;
    } result_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_ready;
    logic [htb_pkg::CMD_W-1:0]    command = htb_pkg::CMD_ALLOC;
    logic [htb_pkg::HANDLE_W-1:0] handle = '0;
    logic [htb_pkg::SIZE_W-1:0]   size = '0;
    logic [htb_pkg::ADDR_W-1:0]   heap_address = '0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic [htb_pkg::STATUS_W-1:0] status;
    logic [htb_pkg::HANDLE_W-1:0] new_handle;
    logic [htb_pkg::ADDR_W-1:0]   resolved_address;
    logic                         release_valid;
    logic [htb_pkg::ADDR_W-1:0]   release_address;
    logic                         last;

    logic [htb_pkg::ADDR_W-1:0] region_base [SLOT_COUNT];
    logic [htb_pkg::SIZE_W-1:0] region_len [SLOT_COUNT];
    result_t                    awaited_results [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int error_count = 0;

    handle_table_with_bounds_check #(
        .SLOT_COUNT(SLOT_COUNT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .command(command),
        .handle(handle),
        .size(size),
        .heap_address(heap_address),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status(status),
        .new_handle(new_handle),
        .resolved_address(resolved_address),
        .release_valid(release_valid),
        .release_address(release_address),
        .last(last)
    );

    initial
    begin
        forever
        begin
            #(HALF_PERIOD) clk = ~clk;
        end
    end

    function automatic void push_result(logic [htb_pkg::STATUS_W-1:0] st,
                                        logic [htb_pkg::HANDLE_W-1:0] nh,
                                        logic [htb_pkg::ADDR_W-1:0] ra, logic rv,
                                        logic [htb_pkg::ADDR_W-1:0] rel, logic fin);
        result_t r;
        r.status = st;
        r.new_handle = nh;
        r.resolved_address = ra;
        r.release_valid = rv;
        r.release_address = rel;
        r.last = fin;
        awaited_results.push_back(r);
    endfunction

    function automatic void apply_command(logic [htb_pkg::CMD_W-1:0] cmd,
                                          logic [htb_pkg::HANDLE_W-1:0] hnd,
                                          logic [htb_pkg::SIZE_W-1:0] len,
                                          logic [htb_pkg::ADDR_W-1:0] addr);
        int          i;
        int          hit;
        int          open_slot;
        int          occupied;
        int          emitted;
        logic [7:0]  top;
        logic [23:0] off;
        logic [24:0] reach;
        top = hnd[31:24];
        off = hnd[23:0];
        hit = -1;
        if (top != 0 && top <= SLOT_COUNT && region_base[top - 1] != '0)
            hit = top - 1;
        case (cmd)
            htb_pkg::CMD_ALLOC:
            begin
                open_slot = -1;
                for (i = SLOT_COUNT - 1; i >= 0; i--)
                    if (region_base[i] == '0)
                        open_slot = i;
                if (open_slot < 0)
                    push_result(htb_pkg::ST_FULL, '0, '0, addr != '0, addr, 1'b1);
                else if (addr == '0)
                    push_result(htb_pkg::ST_ALLOC_FAIL, '0, '0, 1'b0, '0, 1'b1);
                else
                begin
                    region_base[open_slot] = addr;
                    region_len[open_slot] = len;
                    push_result(htb_pkg::ST_OK, {8'(open_slot + 1), 24'h0}, '0, 1'b0, '0,
                                1'b1);
                end
            end
            htb_pkg::CMD_FREE:
            begin
                if (hit < 0 || off != '0)
                    push_result(htb_pkg::ST_BAD_HANDLE, '0, '0, 1'b0, '0, 1'b1);
                else
                begin
                    push_result(htb_pkg::ST_OK, '0, '0, 1'b1, region_base[hit], 1'b1);
                    region_base[hit] = '0;
                end
            end
            htb_pkg::CMD_GETADDR:
            begin
                reach = {1'b0, off} + {1'b0, len};
                if (hit < 0)
                    push_result(htb_pkg::ST_BAD_HANDLE, '0, '0, 1'b0, '0, 1'b1);
                else if ({1'b0, region_len[hit]} < reach)
                    push_result(htb_pkg::ST_RANGE, '0, '0, 1'b0, '0, 1'b1);
                else
                    push_result(htb_pkg::ST_OK, '0, region_base[hit] + {8'h0, off}, 1'b0,
                                '0, 1'b1);
            end
            default:
            begin
                occupied = 0;
                for (i = 0; i < SLOT_COUNT; i++)
                    if (region_base[i] != '0)
                        occupied++;
                if (occupied == 0)
                    push_result(htb_pkg::ST_OK, '0, '0, 1'b0, '0, 1'b1);
                emitted = 0;
                for (i = 0; i < SLOT_COUNT; i++)
                begin
                    if (region_base[i] != '0)
                    begin
                        emitted++;
                        push_result(htb_pkg::ST_OK, '0, '0, 1'b1, region_base[i],
                                    emitted == occupied);
                        region_base[i] = '0;
                    end
                end
            end
        endcase
    endfunction

    task automatic send_word(logic [htb_pkg::CMD_W-1:0] cmd,
                             logic [htb_pkg::HANDLE_W-1:0] hnd,
                             logic [htb_pkg::SIZE_W-1:0] len,
                             logic [htb_pkg::ADDR_W-1:0] addr);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        handle <= hnd;
        size <= len;
        heap_address <= addr;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        apply_command(cmd, hnd, len, addr);
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
                $display("mismatch on %s: expected %h, got %h", name, want, got);
        end
    endtask

    initial
    begin
        result_t want;
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("unexpected word: status %h release %h", status, release_address);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("status", 32'(want.status), 32'(status));
                    check_field("new_handle", want.new_handle, new_handle);
                    check_field("resolved_address", want.resolved_address, resolved_address);
                    check_field("release_valid", 32'(want.release_valid), 32'(release_valid));
                    check_field("release_address", want.release_address, release_address);
                    check_field("last", 32'(want.last), 32'(last));
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic int pick_live_slot();
        int live [$];
        int i;
        for (i = 0; i < SLOT_COUNT; i++)
            if (region_base[i] != '0)
                live.push_back(i);
        if (live.size() == 0)
            return -1;
        return live[$urandom_range(live.size() - 1)];
    endfunction

    task automatic test_empty_table();
        send_word(htb_pkg::CMD_RELEASE, '0, '0, '0);
        send_word(htb_pkg::CMD_GETADDR, 32'h0000_0000, 24'h0, '0);
        send_word(htb_pkg::CMD_FREE, 32'h0100_0000, 24'h0, '0);
        send_word(htb_pkg::CMD_ALLOC, '0, 24'h10, 32'h0);
    endtask

    task automatic test_alloc_and_resolve();
        send_word(htb_pkg::CMD_ALLOC, '0, 24'hFF_FFFF, 32'hFFFF_FFFF);
        send_word(htb_pkg::CMD_ALLOC, 32'hFFFF_FFFF, 24'h0, 32'h0000_0001);
        send_word(htb_pkg::CMD_GETADDR, 32'h0100_0010, 24'hFF_FFEF, '0);
        send_word(htb_pkg::CMD_GETADDR, 32'h01FF_FFFF, 24'hFF_FFFF, '0);
        send_word(htb_pkg::CMD_GETADDR, 32'h0200_0000, 24'h0, '0);
        send_word(htb_pkg::CMD_GETADDR, 32'h0200_0000, 24'h1, '0);
        send_word(htb_pkg::CMD_GETADDR, 32'hFF00_0000, 24'h0, '0);
        send_word(htb_pkg::CMD_GETADDR, 32'h1100_0000, 24'h0, '0);
    endtask

    task automatic test_free_checks();
        send_word(htb_pkg::CMD_FREE, 32'h0200_0001, '0, '0);
        send_word(htb_pkg::CMD_FREE, 32'h0200_0000, '0, '0);
        send_word(htb_pkg::CMD_FREE, 32'h0200_0000, '0, '0);
    endtask

    task automatic test_full_table();
        int i;
        for (i = 0; i < SLOT_COUNT; i++)
            if (region_base[i] == '0)
                send_word(htb_pkg::CMD_ALLOC, '0, 24'($urandom), $urandom | 32'h1);
        send_word(htb_pkg::CMD_ALLOC, '0, 24'h5, 32'hA5A5_0001);
        send_word(htb_pkg::CMD_ALLOC, '0, 24'h5, 32'h0);
        send_word(htb_pkg::CMD_RELEASE, $urandom, 24'($urandom), $urandom);
    endtask

    task automatic test_random_traffic(int count, int idle_pct, int stall_pct);
        int          n;
        int          pick;
        int          s;
        logic [23:0] span;
        logic [23:0] off;
        logic [23:0] len;
        logic [31:0] addr;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            s = pick_live_slot();
            if (pick < 30)
            begin
                addr = ($urandom_range(19) == 0) ? 32'h0 : $urandom;
                len = ($urandom_range(2) == 0) ? 24'($urandom) : 24'($urandom_range(255));
                send_word(htb_pkg::CMD_ALLOC, $urandom, len, addr);
            end
            else if (pick < 65)
            begin
                if (s >= 0 && $urandom_range(4) != 0)
                begin
                    off = 24'($urandom_range(region_len[s]));
                    span = region_len[s] - off;
                    case ($urandom_range(3))
                        0: len = span;
                        1: len = span + 24'h1;
                        2: len = 24'($urandom_range(span));
                        default: len = 24'($urandom);
                    endcase
                    send_word(htb_pkg::CMD_GETADDR, {8'(s + 1), off}, len, $urandom);
                end
                else
                    send_word(htb_pkg::CMD_GETADDR,
                              {8'($urandom_range(SLOT_COUNT + 2)), 24'($urandom)},
                              24'($urandom), $urandom);
            end
            else if (pick < 85)
            begin
                if (s >= 0 && $urandom_range(4) != 0)
                    send_word(htb_pkg::CMD_FREE, {8'(s + 1), 24'h0}, 24'($urandom),
                              $urandom);
                else
                    send_word(htb_pkg::CMD_FREE, {8'($urandom_range(SLOT_COUNT + 2)),
                              ($urandom_range(1) == 0) ? 24'h0 : 24'($urandom)},
                              24'($urandom), $urandom);
            end
            else if (pick < 91)
                send_word(htb_pkg::CMD_RELEASE, $urandom, 24'($urandom), $urandom);
            else
                send_word(2'($urandom), $urandom, 24'($urandom), $urandom);
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_table();
        test_alloc_and_resolve();
        test_free_checks();
        test_full_table();
        test_random_traffic(100, 0, 0);
        test_random_traffic(100, 51, 0);
        test_random_traffic(100, 0, 51);
        test_random_traffic(100, 21, 21);
        in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        error_count += awaited_results.size();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #(6_000_000);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
